// ===== rtl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// shared constants, codes and controller/datapath interface types for the
// warp reconvergence stack
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int LANES         = 32;
  localparam int STACK_ENTRIES = 64;
  localparam int PC_WIDTH      = 16;

  // fixed field widths of the ports
  localparam int CMD_W   = 2;
  localparam int OP_W    = 2;
  localparam int MASK_W  = 32;
  localparam int PCF_W   = 16;
  localparam int DEPTH_W = 7;

  localparam int COUNT_W = $clog2(STACK_ENTRIES + 1);
  localparam int IDX_W   = $clog2(STACK_ENTRIES);

  localparam logic [MASK_W-1:0] LANE_BITS = MASK_W'((64'd1 << LANES) - 64'd1);

  // commands
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ISSUE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd2;

  // retired instruction kinds
  localparam logic [OP_W-1:0] OP_SEQ    = 2'd0;
  localparam logic [OP_W-1:0] OP_JUMP   = 2'd1;
  localparam logic [OP_W-1:0] OP_BRANCH = 2'd2;
  localparam logic [OP_W-1:0] OP_HALT   = 2'd3;

  typedef struct packed {
    logic [MASK_W-1:0]   mask;
    logic [PC_WIDTH-1:0] resume;
    logic [PC_WIDTH-1:0] reconv;
    logic                reconv_ok;
  } frame_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_start;
    logic pop_read;
    logic pop_apply;
    logic retire_step;
    logic push_join;
    logic push_else;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             halted;
    logic             pop_cond;
    logic             diverge;
    logic             stack_full;
  } dp_status_t;

endpackage

// ===== rtl/srs_ctrl.sv =====
// ----------------------------------------------------------------------------
// srs_ctrl
// sequencer for one transaction: evaluate, pop loop, two-step push, report
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output logic                   report,
  input  srs_pkg::dp_status_t    status,
  output srs_pkg::dp_cmd_t       cmd
);
  import srs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE) && (state_r != S_REPORT);
  assign report = (state_r == S_REPORT);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE, S_REPORT: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EVAL: begin
        state_nxt = S_REPORT;
        case (status.command)
          CMD_START: begin
            cmd.do_start = 1'b1;
          end
          CMD_ISSUE: begin
            if (!status.halted && status.pop_cond) begin
              cmd.pop_read = 1'b1;
              state_nxt    = S_POP;
            end
          end
          CMD_RETIRE: begin
            if (!status.halted) begin
              if (status.diverge && !status.stack_full) begin
                cmd.push_join = 1'b1;
                state_nxt     = S_PUSH;
              end else begin
                cmd.retire_step = 1'b1;
              end
            end
          end
          default: begin
            // unused command: report state unchanged
          end
        endcase
      end
      S_POP: begin
        cmd.pop_apply = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_PUSH: begin
        cmd.push_else = 1'b1;
        state_nxt     = S_REPORT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/srs_datapath.sv =====
// ----------------------------------------------------------------------------
// srs_datapath
// warp state registers, frame stack memory and retire arithmetic
// ----------------------------------------------------------------------------
module srs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srs_pkg::dp_cmd_t              cmd,
  output srs_pkg::dp_status_t           status,
  input  logic [srs_pkg::CMD_W-1:0]     in_command,
  input  logic [srs_pkg::MASK_W-1:0]    in_lane_mask,
  input  logic [srs_pkg::OP_W-1:0]      in_op_kind,
  input  logic [srs_pkg::MASK_W-1:0]    in_pred_mask,
  input  logic [srs_pkg::PCF_W-1:0]     in_target_pc,
  input  logic [srs_pkg::PCF_W-1:0]     in_join_pc,
  output logic [srs_pkg::PCF_W-1:0]     pc,
  output logic [srs_pkg::MASK_W-1:0]    live_mask,
  output logic                          halted,
  output logic                          diverged,
  output logic [srs_pkg::DEPTH_W-1:0]   stack_depth,
  output logic                          overflow
);
  import srs_pkg::*;

  // captured transaction
  logic [CMD_W-1:0]    command_r;
  logic [MASK_W-1:0]   lane_mask_r;
  logic [OP_W-1:0]     op_kind_r;
  logic [MASK_W-1:0]   pred_mask_r;
  logic [PC_WIDTH-1:0] target_r;
  logic [PC_WIDTH-1:0] join_r;

  // warp state
  logic [MASK_W-1:0]   live_r;
  logic [PC_WIDTH-1:0] pc_r;
  logic [PC_WIDTH-1:0] rpc_r;
  logic                rvalid_r;
  logic                halt_r;
  logic [COUNT_W-1:0]  count_r;
  logic                div_r;
  logic                ovf_r;

  // frame stack
  frame_t              stack_mem [STACK_ENTRIES];
  frame_t              rd_frame_r;

  logic [MASK_W-1:0]   taken;
  logic [MASK_W-1:0]   other;
  logic [PC_WIDTH-1:0] then_pc;
  logic [COUNT_W-1:0]  top;
  logic                pushing;
  frame_t              wr_frame;

  assign taken   = live_r & pred_mask_r;
  assign other   = live_r & ~pred_mask_r;
  assign then_pc = pc_r + PC_WIDTH'(1);
  assign top     = count_r - COUNT_W'(1);

  assign status.command    = command_r;
  assign status.halted     = halt_r;
  assign status.pop_cond   = (count_r != '0) && rvalid_r && (pc_r == rpc_r);
  assign status.diverge    = (op_kind_r == OP_BRANCH) && (taken != '0) && (other != '0);
  assign status.stack_full = count_r > COUNT_W'(STACK_ENTRIES - 2);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_r   <= in_command;
      lane_mask_r <= in_lane_mask;
      op_kind_r   <= in_op_kind;
      pred_mask_r <= in_pred_mask;
      target_r    <= PC_WIDTH'(in_target_pc);
      join_r      <= PC_WIDTH'(in_join_pc);
    end
  end

  // frame memory: one write, one registered read per cycle
  assign pushing = cmd.push_join || cmd.push_else;

  always_comb begin
    if (cmd.push_join) begin
      wr_frame = '{mask: live_r, resume: join_r, reconv: rpc_r, reconv_ok: rvalid_r};
    end else begin
      wr_frame = '{mask: other, resume: target_r, reconv: join_r, reconv_ok: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (pushing) begin
      stack_mem[count_r[IDX_W-1:0]] <= wr_frame;
    end
    if (cmd.pop_read) begin
      rd_frame_r <= stack_mem[top[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      pc_r     <= '0;
      rpc_r    <= '0;
      rvalid_r <= 1'b0;
      halt_r   <= 1'b0;
      count_r  <= '0;
      div_r    <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      if (cmd.capture) begin
        div_r <= 1'b0;
        ovf_r <= 1'b0;
      end
      if (cmd.do_start) begin
        live_r   <= lane_mask_r & LANE_BITS;
        pc_r     <= '0;
        rpc_r    <= '0;
        rvalid_r <= 1'b0;
        halt_r   <= 1'b0;
        count_r  <= '0;
      end
      if (cmd.pop_apply) begin
        live_r   <= rd_frame_r.mask;
        pc_r     <= rd_frame_r.resume;
        rpc_r    <= rd_frame_r.reconv;
        rvalid_r <= rd_frame_r.reconv_ok;
        count_r  <= top;
      end
      if (cmd.retire_step) begin
        case (op_kind_r)
          OP_SEQ:  pc_r   <= then_pc;
          OP_JUMP: pc_r   <= target_r;
          OP_HALT: halt_r <= 1'b1;
          default: begin
            // branch: uniform redirect, or divergent with no room
            if (taken == '0 || other == '0) begin
              pc_r <= (taken != '0) ? then_pc : target_r;
            end else begin
              halt_r <= 1'b1;
              ovf_r  <= 1'b1;
            end
          end
        endcase
      end
      if (cmd.push_join) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.push_else) begin
        count_r  <= count_r + COUNT_W'(1);
        live_r   <= taken;
        pc_r     <= then_pc;
        rpc_r    <= join_r;
        rvalid_r <= 1'b1;
        div_r    <= 1'b1;
      end
    end
  end

  assign pc          = PCF_W'(pc_r);
  assign live_mask   = live_r;
  assign halted      = halt_r;
  assign diverged    = div_r;
  assign stack_depth = DEPTH_W'(count_r);
  assign overflow    = ovf_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(STACK_ENTRIES))
    else $error("stack depth beyond capacity");

  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_else |-> $past(cmd.push_join))
    else $error("else frame pushed without join frame");

  a_pop_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_apply |-> $past(cmd.pop_read))
    else $error("pop applied without stack read");

  a_div_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_r && ovf_r))
    else $error("divergence and overflow flagged together");

endmodule

// ===== rtl/simt_reconvergence_stack.sv =====
// ----------------------------------------------------------------------------
// simt_reconvergence_stack
// control flow of one warp with post-dominator reconvergence stack
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each transaction
// yields exactly one result, shown for one cycle with out_valid high; the
// receiver cannot stall it, so sample it in that cycle. Start, retire and
// unused commands go from accept through the evaluate state to the result
// cycle; the next transaction may be accepted in that result cycle, not
// before. A divergent branch adds a push state (two frame writes through the
// one stack memory port). An issue goes through a pop state and back to
// evaluate per frame popped; each pop is a registered stack read then a state
// update. No reset sweep: stack entries are only read after being pushed.
module simt_reconvergence_stack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [srs_pkg::CMD_W-1:0]     in_command,
  input  logic [srs_pkg::MASK_W-1:0]    in_lane_mask,
  input  logic [srs_pkg::OP_W-1:0]      in_op_kind,
  input  logic [srs_pkg::MASK_W-1:0]    in_pred_mask,
  input  logic [srs_pkg::PCF_W-1:0]     in_target_pc,
  input  logic [srs_pkg::PCF_W-1:0]     in_join_pc,
  output logic                          out_valid,
  output logic [srs_pkg::PCF_W-1:0]     out_pc,
  output logic [srs_pkg::MASK_W-1:0]    out_live_mask,
  output logic                          out_halted,
  output logic                          out_diverged,
  output logic [srs_pkg::DEPTH_W-1:0]   out_stack_depth,
  output logic                          out_overflow
);
  import srs_pkg::*;

  // command bus from sequencer, status back from datapath
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  srs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .report (out_valid),
    .status (dp_status),
    .cmd    (dp_cmd)
  );

  // result fields come straight from state registers, stable in result cycle
  srs_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .in_command   (in_command),
    .in_lane_mask (in_lane_mask),
    .in_op_kind   (in_op_kind),
    .in_pred_mask (in_pred_mask),
    .in_target_pc (in_target_pc),
    .in_join_pc   (in_join_pc),
    .pc           (out_pc),
    .live_mask    (out_live_mask),
    .halted       (out_halted),
    .diverged     (out_diverged),
    .stack_depth  (out_stack_depth),
    .overflow     (out_overflow)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the warp reconvergence stack: a cycle-free predictor
// tracks pc, lane mask and frame stack, every accepted transaction queues its
// expected result, every out_valid strobe is compared field by field
// ----------------------------------------------------------------------------
module testbench;
  import srs_pkg::*;

  // command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int ITEM_GOAL    = 1700;
  // longest correct quiet stretch is a full 62-frame pop cascade
  // plus a sender gap, so this leaves a wide margin
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [MASK_W-1:0] lane_mask;
    logic [OP_W-1:0]   op_kind;
    logic [MASK_W-1:0] pred_mask;
    logic [PCF_W-1:0]  target_pc;
    logic [PCF_W-1:0]  join_pc;
  } warp_item_t;

  typedef struct {
    logic [PCF_W-1:0]   pc;
    logic [MASK_W-1:0]  live_mask;
    logic               halted;
    logic               diverged;
    logic [DEPTH_W-1:0] stack_depth;
    logic               overflow;
  } warp_state_t;

  // predicts the warp state after each transaction and holds the results
  // still owed by the block, oldest first
  class warp_flow_predictor;
    logic [MASK_W-1:0] live = '0;
    logic [PCF_W-1:0]  pc = '0;
    logic [PCF_W-1:0]  reconv = '0;
    logic              reconv_ok = 1'b0;
    logic              halted = 1'b0;
    int                depth = 0;
    frame_t            frames[STACK_ENTRIES];
    warp_state_t       pending[$];
    int                errors = 0;

    function void note_item(warp_item_t it);
      warp_state_t       r;
      logic [MASK_W-1:0] taken;
      logic [MASK_W-1:0] other;
      logic [PCF_W-1:0]  then_pc;
      r.diverged = 1'b0;
      r.overflow = 1'b0;
      case (it.command)
        CMD_START: begin
          live      = it.lane_mask & LANE_BITS;
          pc        = '0;
          reconv    = '0;
          reconv_ok = 1'b0;
          halted    = 1'b0;
          depth     = 0;
        end
        CMD_ISSUE: begin
          // pop frames for as long as the pc sits on the reconvergence point
          if (!halted) begin
            while (depth > 0 && reconv_ok && pc == reconv) begin
              depth--;
              live      = frames[depth].mask;
              pc        = frames[depth].resume;
              reconv    = frames[depth].reconv;
              reconv_ok = frames[depth].reconv_ok;
            end
          end
        end
        CMD_RETIRE: begin
          if (!halted) begin
            case (it.op_kind)
              OP_SEQ:  pc = pc + 1'b1;
              OP_JUMP: pc = it.target_pc;
              OP_HALT: halted = 1'b1;
              OP_BRANCH: begin
                taken   = live & it.pred_mask;
                other   = live & ~it.pred_mask;
                then_pc = pc + 1'b1;
                if (taken == '0 || other == '0) begin
                  // uniform, including no active lane at all
                  pc = (taken != '0) ? then_pc : it.target_pc;
                end else if (depth + 2 > STACK_ENTRIES) begin
                  halted     = 1'b1;
                  r.overflow = 1'b1;
                end else begin
                  frames[depth] = '{mask: live, resume: it.join_pc, reconv: reconv,
                                    reconv_ok: reconv_ok};
                  depth++;
                  frames[depth] = '{mask: other, resume: it.target_pc,
                                    reconv: it.join_pc, reconv_ok: 1'b1};
                  depth++;
                  live       = taken;
                  pc         = then_pc;
                  reconv     = it.join_pc;
                  reconv_ok  = 1'b1;
                  r.diverged = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      r.pc          = pc;
      r.live_mask   = live;
      r.halted      = halted;
      r.stack_depth = DEPTH_W'(depth);
      pending.insert(pending.size(), r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_state(warp_state_t got);
      warp_state_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: pc %h mask %h", $time, got.pc, got.live_mask);
        return;
      end
      want = pending.pop_front();
      compare_field("pc", want.pc, got.pc);
      compare_field("live_mask", want.live_mask, got.live_mask);
      compare_field("halted", want.halted, got.halted);
      compare_field("diverged", want.diverged, got.diverged);
      compare_field("stack_depth", want.stack_depth, got.stack_depth);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  // clock and block ports; the clock and the driven inputs are known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   in_command = '0;
  logic [MASK_W-1:0]  in_lane_mask = '0;
  logic [OP_W-1:0]    in_op_kind = '0;
  logic [MASK_W-1:0]  in_pred_mask = '0;
  logic [PCF_W-1:0]   in_target_pc = '0;
  logic [PCF_W-1:0]   in_join_pc = '0;
  logic               out_valid;
  logic [PCF_W-1:0]   out_pc;
  logic [MASK_W-1:0]  out_live_mask;
  logic               out_halted;
  logic               out_diverged;
  logic [DEPTH_W-1:0] out_stack_depth;
  logic               out_overflow;

  warp_flow_predictor flow;
  warp_state_t        seen;
  int                 idle_pct = 0;
  int                 items_done = 0;
  int                 quiet_cycles = 0;
  int                 idle_phases[3] = '{0, 49, 17};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  simt_reconvergence_stack uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_lane_mask    (in_lane_mask),
    .in_op_kind      (in_op_kind),
    .in_pred_mask    (in_pred_mask),
    .in_target_pc    (in_target_pc),
    .in_join_pc      (in_join_pc),
    .out_valid       (out_valid),
    .out_pc          (out_pc),
    .out_live_mask   (out_live_mask),
    .out_halted      (out_halted),
    .out_diverged    (out_diverged),
    .out_stack_depth (out_stack_depth),
    .out_overflow    (out_overflow)
  );

  // result side: one strobe per result, taken at the edge ending its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.pc          = out_pc;
      seen.live_mask   = out_live_mask;
      seen.halted      = out_halted;
      seen.diverged    = out_diverged;
      seen.stack_depth = out_stack_depth;
      seen.overflow    = out_overflow;
      flow.check_state(seen);
    end
  end

  // watchdog: too long without any transaction accepted or any result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one transaction: random sender gaps first, then hold start until taken;
  // start stays high on return so back-to-back transactions need no extra write
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [MASK_W-1:0] lanes,
                      input logic [OP_W-1:0] op, input logic [MASK_W-1:0] pred,
                      input logic [PCF_W-1:0] tgt, input logic [PCF_W-1:0] jpc);
    warp_item_t it;
    it = '{command: cmd, lane_mask: lanes, op_kind: op, pred_mask: pred,
           target_pc: tgt, join_pc: jpc};
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_lane_mask <= lanes;
    in_op_kind   <= op;
    in_pred_mask <= pred;
    in_target_pc <= tgt;
    in_join_pc   <= jpc;
    do @(posedge clk); while (busy);
    // ignored transactions do not count toward the goal
    if (cmd == CMD_START || (cmd != CMD_UNUSED && !flow.halted)) items_done++;
    flow.note_item(it);
  endtask

  // issue ignores every field but the command, so those get random bits
  task automatic send_issue();
    send(CMD_ISSUE, $urandom, OP_W'($urandom_range(3)), $urandom, $urandom, $urandom);
  endtask

  task automatic send_retire(input logic [OP_W-1:0] op, input logic [MASK_W-1:0] pred,
                             input logic [PCF_W-1:0] tgt, input logic [PCF_W-1:0] jpc);
    send(CMD_RETIRE, $urandom, op, pred, tgt, jpc);
  endtask

  function automatic logic [MASK_W-1:0] pick_lanes();
    case ($urandom_range(7))
      0: return '1;
      1: return MASK_W'(1) << $urandom_range(MASK_W - 1);
      2: return ($urandom_range(3) == 0) ? '0 : $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  // well-formed warp program: issue/retire pairs, branch joins kept inside the
  // enclosing reconvergence region so that sequential steps reach them
  task automatic run_episode();
    int                steps;
    int                pick;
    logic [PCF_W-1:0]  span;
    logic [PCF_W-1:0]  dist_pc;
    logic [PCF_W-1:0]  jpc;
    logic [PCF_W-1:0]  tgt;
    logic [MASK_W-1:0] pred;
    send(CMD_START, pick_lanes(), OP_W'($urandom_range(3)), $urandom, $urandom, $urandom);
    steps = $urandom_range(60, 8);
    repeat (steps) begin
      if (flow.halted) break;
      send_issue();
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_retire(OP_SEQ, $urandom, $urandom, $urandom);
      end else if (pick < 75) begin
        span = 16'd8;
        if (flow.reconv_ok && PCF_W'(flow.reconv - flow.pc) >= 16'd2 &&
            PCF_W'(flow.reconv - flow.pc) < 16'd8) span = flow.reconv - flow.pc;
        dist_pc = PCF_W'($urandom_range(span, 2));
        jpc = flow.pc + dist_pc;
        case ($urandom_range(9))
          0: pred = '0;
          1: pred = '1;
          default: pred = $urandom;
        endcase
        // now and then a branch with wild targets
        if ($urandom_range(11) == 0) send_retire(OP_BRANCH, pred, $urandom, $urandom);
        else send_retire(OP_BRANCH, pred, flow.pc + PCF_W'($urandom_range(dist_pc, 1)), jpc);
      end else if (pick < 87) begin
        case ($urandom_range(3))
          0, 1: tgt = flow.reconv_ok ? flow.reconv : flow.pc + 1'b1;
          2: tgt = flow.pc + PCF_W'($urandom_range(3));
          default: tgt = $urandom;
        endcase
        send_retire(OP_JUMP, $urandom, tgt, $urandom);
      end else if (pick < 89) begin
        send_retire(OP_HALT, $urandom, $urandom, $urandom);
      end else begin
        // noise: any command, any field
        send(CMD_W'($urandom_range(3)), $urandom, OP_W'($urandom_range(3)), $urandom,
             $urandom, $urandom);
      end
    end
  endtask

  // nest divergent branches until one lane is left, all sharing one join,
  // then jump to the join so that a single issue unwinds the whole stack
  task automatic run_deep_nest();
    logic [PCF_W-1:0]  jpc;
    logic [MASK_W-1:0] pred;
    logic [MASK_W-1:0] keep;
    int                lane;
    send(CMD_START, $urandom_range(1) ? '1 : ($urandom | $urandom | $urandom),
         OP_W'($urandom_range(3)), $urandom, $urandom, $urandom);
    jpc = 16'h8000 | PCF_W'($urandom_range(16'h7fff));
    while ((flow.live & (flow.live - 1'b1)) != '0) begin
      do lane = $urandom_range(MASK_W - 1); while (!flow.live[lane]);
      pred = flow.live & ~(MASK_W'(1) << lane);
      keep = $urandom;
      // mostly one lane dropped per level, sometimes several
      if ($urandom_range(3) == 0 && (pred & keep) != '0) pred = pred & keep;
      // predicate bits of inactive lanes must not matter
      pred = pred | (~flow.live & $urandom);
      send_issue();
      send_retire(OP_BRANCH, pred, jpc, jpc);
    end
    // one lane left: always uniform, even with the stack nearly full
    send_retire(OP_BRANCH, $urandom, jpc, jpc);
    send_retire(OP_JUMP, $urandom, jpc, $urandom);
    send_issue();
    send_issue();
  endtask

  initial begin
    int episode;
    flow = new();
    episode = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, pc wrap, divergence and reconvergence, uniform
    // branches, unused command, halted warp, empty lane mask
    send_issue();
    send_retire(OP_SEQ, '1, '1, '1);
    send(CMD_START, '1, OP_BRANCH, '0, '0, '0);
    send_issue();
    send_retire(OP_SEQ, '0, '0, '0);
    send_retire(OP_JUMP, '0, 16'hffff, '0);
    send_retire(OP_SEQ, '1, '0, '1);
    send_retire(OP_JUMP, '1, 16'hffff, '1);
    send_retire(OP_BRANCH, 32'haaaa_aaaa, 16'h0001, 16'h0002);
    send_issue();
    send_retire(OP_SEQ, '0, '0, '0);
    send_issue();
    send_retire(OP_SEQ, '0, '0, '0);
    send_issue();
    send_retire(OP_SEQ, '0, '0, '0);
    send_issue();
    send_retire(OP_BRANCH, '0, 16'h0100, 16'h0200);
    send_retire(OP_BRANCH, '1, 16'h0300, 16'h0400);
    send(CMD_UNUSED, '1, OP_HALT, '1, '1, '1);
    send_retire(OP_HALT, '0, '0, '0);
    send_issue();
    send_retire(OP_BRANCH, 32'h0000_ffff, 16'h1234, 16'h5678);
    send(CMD_START, '0, OP_SEQ, '0, '0, '0);
    send_retire(OP_BRANCH, 32'h5555_5555, 16'h00ff, 16'hff00);

    // random programs, sender gap pressure changes every few episodes
    while (items_done < ITEM_GOAL) begin
      idle_pct = idle_phases[(episode / 3) % 3];
      if (episode % 7 == 3) run_deep_nest();
      else run_episode();
      episode++;
    end
    start <= 1'b0;

    while (flow.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (flow.pending.size() != 0)
      $display("%0t missing results: %0d", $time, flow.pending.size());
    if (flow.errors == 0 && flow.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
